[rtl/core/mono_framebuffer_rect_fill_page_pack_core_macros.svh]
// Assertion macros for the mono framebuffer rect fill / page pack core.
// Expects clk and rst in the scope of the module that uses them.
`ifndef MONO_FRAMEBUFFER_RECT_FILL_PAGE_PACK_CORE_MACROS_SVH
`define MONO_FRAMEBUFFER_RECT_FILL_PAGE_PACK_CORE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define MFBRF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define MFBRF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/mfbrf_pkg.sv]
// Shared constants and types for the mono framebuffer rect fill / page pack core.
// No dependencies.
`timescale 1ns / 1ps

package mfbrf_pkg;

  localparam int DISPLAY_ROWS_DEF    = 32;
  localparam int DISPLAY_COLUMNS_DEF = 128;
  localparam int PAGE_ROWS           = 8;

  // Command and response field widths
  localparam int OPCODE_W = 2;
  localparam int X_W      = 7;
  localparam int Y_W      = 5;
  localparam int WIDTH_W  = 7;
  localparam int HEIGHT_W = 5;
  localparam int INDEX_W  = 9;
  localparam int DATA_W   = 8;

  typedef enum logic [OPCODE_W-1:0] {
    OP_FILL  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_PACK  = 2'd2,
    OP_READ  = 2'd3
  } opcode_t;

endpackage

[rtl/core/mfbrf_if.sv]
// Command and response channel interfaces (valid/ready).
// Depends on mfbrf_pkg for field widths.
`timescale 1ns / 1ps

interface mfbrf_cmd_if import mfbrf_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [X_W-1:0]      x_pos;
  logic [Y_W-1:0]      y_pos;
  logic [WIDTH_W-1:0]  rect_width;
  logic [HEIGHT_W-1:0] rect_height;
  logic [INDEX_W-1:0]  byte_index;

  modport source (output valid, opcode, x_pos, y_pos, rect_width, rect_height, byte_index,
                  input ready);
  modport sink   (input valid, opcode, x_pos, y_pos, rect_width, rect_height, byte_index,
                  output ready);
endinterface

interface mfbrf_rsp_if import mfbrf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;

  modport source (output valid, read_data, input ready);
  modport sink   (input valid, read_data, output ready);
endinterface

[rtl/core/mono_framebuffer_rect_fill_page_pack_core.sv]
// Every command gets one response beat; an empty fill or an out-of-range read goes
// straight to it without walking any rows.
// One command at a time; throughput is set by the row-wide read and write ports of each
// memory, one row per cycle. Reset: synchronous clearing pass over both memories, no
// command beat taken meanwhile; no response beat for it.
`timescale 1ns / 1ps
`include "mono_framebuffer_rect_fill_page_pack_core_macros.svh"

module mono_framebuffer_rect_fill_page_pack_core
  import mfbrf_pkg::*;
#(
  parameter int DISPLAY_ROWS    = DISPLAY_ROWS_DEF,
  parameter int DISPLAY_COLUMNS = DISPLAY_COLUMNS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  mfbrf_cmd_if.sink cmd,
  mfbrf_rsp_if.source rsp
);

  localparam int PAGE_COUNT   = (DISPLAY_ROWS + PAGE_ROWS - 1) / PAGE_ROWS;
  localparam int BUFFER_BYTES = DISPLAY_COLUMNS * PAGE_COUNT;
  localparam int RW  = $clog2(DISPLAY_ROWS);
  localparam int CW  = $clog2(DISPLAY_COLUMNS);
  localparam int PW  = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int BW  = $clog2(PAGE_ROWS);
  // counters wide enough for y+height, page rows and the row count itself
  localparam int RCW = $clog2(PAGE_COUNT * PAGE_ROWS + 2 * (1 << Y_W));
  localparam int CCW = $clog2(DISPLAY_COLUMNS + 2 * (1 << X_W));
  localparam int IW  = $clog2(BUFFER_BYTES + (1 << INDEX_W));

  localparam logic [RCW-1:0] ROW_LAST = RCW'(DISPLAY_ROWS - 1);
  localparam logic [RCW-1:0] ROW_CNT  = RCW'(DISPLAY_ROWS);
  localparam logic [CCW-1:0] COL_LAST = CCW'(DISPLAY_COLUMNS - 1);
  localparam logic [BW-1:0]  BIT_LAST = BW'(PAGE_ROWS - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FILL,
    S_PACK,
    S_READ,
    S_DONE
  } state_t;

  // ---------------------------------------------------------------------------
  // Memories. pix_mem is the live pixel map, one row per entry. snap_mem is the
  // page buffer held as a row snapshot taken by pack; a page byte is gathered
  // from eight snapshot rows at read time.
  // ---------------------------------------------------------------------------
  logic [DISPLAY_COLUMNS-1:0] pix_mem  [DISPLAY_ROWS];
  logic [DISPLAY_COLUMNS-1:0] snap_mem [DISPLAY_ROWS];

  logic                       pix_we,   snap_we;
  logic [RW-1:0]              pix_waddr, snap_waddr;
  logic [RW-1:0]              pix_raddr, snap_raddr;
  logic [DISPLAY_COLUMNS-1:0] pix_wdata, snap_wdata;
  logic [DISPLAY_COLUMNS-1:0] pix_rdata, snap_rdata;

  always_ff @(posedge clk) begin
    if (pix_we) begin
      pix_mem[pix_waddr] <= pix_wdata;
    end
    pix_rdata <= pix_mem[pix_raddr];
  end

  always_ff @(posedge clk) begin
    if (snap_we) begin
      snap_mem[snap_waddr] <= snap_wdata;
    end
    snap_rdata <= snap_mem[snap_raddr];
  end

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  state_t                     state;
  logic [RCW-1:0]             cnt;        // row walker, or bit number during read
  logic [RCW-1:0]             row_end;    // last row to walk
  logic                       issuing;    // read side of the row walk still active
  logic                       wb_valid;   // row read last cycle, write back now
  logic [RW-1:0]              wb_row;
  logic [DISPLAY_COLUMNS-1:0] col_mask;   // fill columns
  logic                       clr_report; // clear came from a command, not reset
  logic [PW-1:0]              rd_page;
  logic [CW-1:0]              rd_col;
  logic                       cap_valid;  // snapshot row arriving, capture its bit
  logic [BW-1:0]              cap_bit;
  logic [DATA_W-1:0]          rd_byte;

  // ---------------------------------------------------------------------------
  // Command decode: rectangle clipping, column mask, byte index split
  // ---------------------------------------------------------------------------
  logic [RCW-1:0]             y_ext, y_end, fill_row_end;
  logic [CCW-1:0]             x_ext, x_end, col_end;
  logic                       fill_empty;
  logic [DISPLAY_COLUMNS-1:0] fill_mask;
  logic [IW-1:0]              idx_ext;
  logic                       idx_hit;
  logic [PW-1:0]              idx_page;
  logic [CW-1:0]              idx_col;

  always_comb begin
    y_ext        = RCW'(cmd.y_pos);
    y_end        = y_ext + RCW'(cmd.rect_height);
    fill_row_end = (y_end > ROW_LAST) ? ROW_LAST : y_end;
    x_ext        = CCW'(cmd.x_pos);
    x_end        = x_ext + CCW'(cmd.rect_width);
    col_end      = (x_end > COL_LAST) ? COL_LAST : x_end;
    // rectangle starting off-screen sets nothing
    fill_empty   = (y_ext > ROW_LAST) || (x_ext > COL_LAST);
    for (int c = 0; c < DISPLAY_COLUMNS; c++) begin
      fill_mask[c] = (CCW'(c) >= x_ext) && (CCW'(c) <= col_end);
    end
  end

  // byte index = column + DISPLAY_COLUMNS * page; one compare pair per page
  always_comb begin
    idx_ext  = IW'(cmd.byte_index);
    idx_hit  = 1'b0;
    idx_page = '0;
    idx_col  = '0;
    for (int p = 0; p < PAGE_COUNT; p++) begin
      if (idx_ext >= IW'(p * DISPLAY_COLUMNS) && idx_ext < IW'((p + 1) * DISPLAY_COLUMNS)) begin
        idx_hit  = 1'b1;
        idx_page = PW'(p);
        idx_col  = CW'(idx_ext - IW'(p * DISPLAY_COLUMNS));
      end
    end
  end

  // Row of the snapshot holding bit cnt of the page being read. Rows past the
  // bottom edge of a partial last page read as zero bits.
  logic [RCW-1:0] rd_row;
  logic           rd_row_ok;

  assign rd_row    = RCW'({rd_page, cnt[BW-1:0]});
  assign rd_row_ok = rd_row < ROW_CNT;

  // ---------------------------------------------------------------------------
  // Memory port steering
  // ---------------------------------------------------------------------------
  always_comb begin
    pix_we     = 1'b0;
    pix_waddr  = wb_row;
    pix_wdata  = pix_rdata | col_mask;  // fill only ever sets pixels
    pix_raddr  = cnt[RW-1:0];
    snap_we    = 1'b0;
    snap_waddr = wb_row;
    snap_wdata = pix_rdata;             // pack copies the live row
    snap_raddr = rd_row[RW-1:0];
    unique case (state)
      S_CLEAR: begin
        pix_we     = 1'b1;
        pix_waddr  = cnt[RW-1:0];
        pix_wdata  = '0;
        snap_we    = 1'b1;
        snap_waddr = cnt[RW-1:0];
        snap_wdata = '0;
      end
      S_FILL:  pix_we  = wb_valid;
      S_PACK:  snap_we = wb_valid;
      S_IDLE, S_READ, S_DONE: ;
      default: ;
    endcase
  end

  assign cmd.ready = (state == S_IDLE);

  // ---------------------------------------------------------------------------
  // Sequencer. Fill and pack walk rows with a one-deep read/write-back pipe:
  // row r is read while row r-1 is written, so the same row never overlaps.
  // Read issues eight snapshot reads and captures one bit from each that lies on the screen.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      cnt        <= '0;
      issuing    <= 1'b0;
      wb_valid   <= 1'b0;
      cap_valid  <= 1'b0;
      clr_report <= 1'b0;
      rsp.valid  <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      wb_valid  <= 1'b0;
      cap_valid <= 1'b0;
      if (cap_valid) begin
        rd_byte[cap_bit] <= snap_rdata[rd_col];
      end

      unique case (state)
        S_CLEAR: begin
          if (cnt == ROW_LAST) begin
            cnt   <= '0;
            state <= clr_report ? S_DONE : S_IDLE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end

        S_IDLE: begin
          if (cmd.valid) begin
            cnt     <= '0;
            rd_byte <= '0;
            unique case (opcode_t'(cmd.opcode))
              OP_FILL: begin
                if (fill_empty) begin
                  state <= S_DONE;
                end else begin
                  cnt      <= y_ext;
                  row_end  <= fill_row_end;
                  col_mask <= fill_mask;
                  issuing  <= 1'b1;
                  state    <= S_FILL;
                end
              end
              OP_CLEAR: begin
                clr_report <= 1'b1;
                state      <= S_CLEAR;
              end
              OP_PACK: begin
                row_end <= ROW_LAST;
                issuing <= 1'b1;
                state   <= S_PACK;
              end
              OP_READ: begin
                if (idx_hit) begin
                  rd_page <= idx_page;
                  rd_col  <= idx_col;
                  issuing <= 1'b1;
                  state   <= S_READ;
                end else begin
                  state <= S_DONE;
                end
              end
              default: state <= S_DONE;
            endcase
          end
        end

        S_FILL, S_PACK: begin
          if (issuing) begin
            wb_valid <= 1'b1;
            wb_row   <= cnt[RW-1:0];
            if (cnt == row_end) begin
              issuing <= 1'b0;
            end else begin
              cnt <= cnt + 1'b1;
            end
          end else if (!wb_valid) begin
            state <= S_DONE;
          end
        end

        S_READ: begin
          if (issuing) begin
            cap_valid <= rd_row_ok;
            cap_bit   <= cnt[BW-1:0];
            if (cnt[BW-1:0] == BIT_LAST) begin
              issuing <= 1'b0;
            end else begin
              cnt <= cnt + 1'b1;
            end
          end else if (!cap_valid) begin
            state <= S_DONE;
          end
        end

        S_DONE: begin
          // hold until the response register is free
          if (!rsp.valid || rsp.ready) begin
            rsp.valid     <= 1'b1;
            rsp.read_data <= rd_byte;
            clr_report    <= 1'b0;
            state         <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `MFBRF_ASSERT_NEXT(a_one_at_a_time, cmd.valid && cmd.ready, !cmd.ready, "command taken while busy")
  `MFBRF_ASSERT_NOW(a_rsp_from_done, $rose(rsp.valid), $past(state == S_DONE), "stray response beat")
  `MFBRF_ASSERT_NOW(a_fill_no_overlap, (state == S_FILL) && wb_valid && issuing, pix_raddr != wb_row, "fill read/write-back collide on one row")

endmodule

[test/tb_mono_framebuffer_rect_fill_page_pack_core.sv]
// Testbench for mono_framebuffer_rect_fill_page_pack_core: a directed and random mix of
// fill, clear, pack and read commands, every response checked against an in-bench model.
// Depends on mfbrf_pkg and the mfbrf_cmd_if / mfbrf_rsp_if interfaces.
`timescale 1ns / 1ps

module tb_mono_framebuffer_rect_fill_page_pack_core;
  import mfbrf_pkg::*;

  localparam int ROWS      = DISPLAY_ROWS_DEF;
  localparam int COLS      = DISPLAY_COLUMNS_DEF;
  localparam int PAGES     = (ROWS + PAGE_ROWS - 1) / PAGE_ROWS;
  localparam int BUF_BYTES = COLS * PAGES;
  localparam int RAND_CMDS = 800;
  // the slowest commands are a pack and a whole-screen fill; drain past them
  localparam int DRAIN_CYCLES = ROWS + 8;
  localparam int IDLE_PCT     = 8;
  // window of cycles where neither side idles (back-to-back beats)
  localparam int QUIET_FROM = 8000;
  localparam int QUIET_TO   = 14000;

  typedef struct packed {
    opcode_t             opcode;
    logic [X_W-1:0]      x_pos;
    logic [Y_W-1:0]      y_pos;
    logic [WIDTH_W-1:0]  rect_width;
    logic [HEIGHT_W-1:0] rect_height;
    logic [INDEX_W-1:0]  byte_index;
  } fb_cmd_t;

  logic clk;
  logic rst;

  mfbrf_cmd_if cmd_ch ();
  mfbrf_rsp_if rsp_ch ();

  mono_framebuffer_rect_fill_page_pack_core i_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // ---------------------------------------------------------------------------
  // Shadow framebuffer: pixel rows and the packed page bytes
  // ---------------------------------------------------------------------------
  logic [COLS-1:0]     frame_bits [ROWS];
  logic [DATA_W-1:0]   page_bytes [BUF_BYTES];

  fb_cmd_t             pending_cmds [$];   // filled up front, drained by the driver
  logic [DATA_W-1:0]   expected_bytes [$]; // one entry per accepted command
  int                  mismatch_cnt = 0;
  int                  cmds_accepted = 0;
  int                  total_cmds;
  int                  cyc = 0;
  logic                cmd_fire = 1'b0;    // command beat taken at the last rising edge
  fb_cmd_t             next_cmd;

  function automatic void clear_shadow();
    for (int r = 0; r < ROWS; r++) frame_bits[r] = '0;
    for (int i = 0; i < BUF_BYTES; i++) page_bytes[i] = '0;
  endfunction

  // Applies one command to the shadow state and returns the response byte.
  function automatic logic [DATA_W-1:0] apply_fb_cmd(fb_cmd_t c);
    int r_last;
    int c_last;
    int idx;
    logic [DATA_W-1:0] b;
    logic [DATA_W-1:0] rd;
    rd = '0;
    case (c.opcode)
      OP_FILL: begin
        // inclusive span, clipped at the right and bottom edges
        r_last = int'(c.y_pos) + int'(c.rect_height);
        c_last = int'(c.x_pos) + int'(c.rect_width);
        if (r_last > ROWS - 1) r_last = ROWS - 1;
        if (c_last > COLS - 1) c_last = COLS - 1;
        for (int r = int'(c.y_pos); r <= r_last; r++)
          for (int k = int'(c.x_pos); k <= c_last; k++)
            frame_bits[r][k] = 1'b1;
      end
      OP_CLEAR: clear_shadow();
      OP_PACK: begin
        // bit n of a page byte is row 8*page+n; rows past the screen pack as zero
        for (int p = 0; p < PAGES; p++)
          for (int k = 0; k < COLS; k++) begin
            b = '0;
            for (int n = 0; n < PAGE_ROWS; n++)
              if (p * PAGE_ROWS + n < ROWS) b[n] = frame_bits[p * PAGE_ROWS + n][k];
            page_bytes[k + p * COLS] = b;
          end
      end
      default: begin
        idx = int'(c.byte_index);
        if (idx < BUF_BYTES) rd = page_bytes[idx];
      end
    endcase
    return rd;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatch_cnt++;
  endtask

  task automatic queue_cmd(input opcode_t op, input int x, input int y, input int w,
                           input int h, input int idx);
    fb_cmd_t c;
    c.opcode      = op;
    c.x_pos       = X_W'(x);
    c.y_pos       = Y_W'(y);
    c.rect_width  = WIDTH_W'(w);
    c.rect_height = HEIGHT_W'(h);
    c.byte_index  = INDEX_W'(idx);
    pending_cmds.push_back(c);
  endtask

  function automatic bit quiet_window();
    return (cyc >= QUIET_FROM) && (cyc < QUIET_TO);
  endfunction

  // ---------------------------------------------------------------------------
  // Command driver: changes on the falling edge, holds a beat until it is taken
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      cmd_ch.valid <= 1'b0;
    end else if (!cmd_ch.valid || cmd_fire) begin
      if (pending_cmds.size() != 0 &&
          (quiet_window() || $urandom_range(0, 99) >= IDLE_PCT)) begin
        next_cmd = pending_cmds.pop_front();
        cmd_ch.valid       <= 1'b1;
        cmd_ch.opcode      <= next_cmd.opcode;
        cmd_ch.x_pos       <= next_cmd.x_pos;
        cmd_ch.y_pos       <= next_cmd.y_pos;
        cmd_ch.rect_width  <= next_cmd.rect_width;
        cmd_ch.rect_height <= next_cmd.rect_height;
        cmd_ch.byte_index  <= next_cmd.byte_index;
      end else begin
        cmd_ch.valid <= 1'b0;
      end
    end
  end

  // Response back-pressure, also on the falling edge
  always @(negedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= quiet_window() || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: samples both channels at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    fb_cmd_t           seen;
    logic [DATA_W-1:0] want;
    cyc <= cyc + 1;
    if (rst) begin
      cmd_fire <= 1'b0;
    end else begin
      cmd_fire <= cmd_ch.valid && cmd_ch.ready;
      if (cmd_ch.valid && cmd_ch.ready) begin
        seen.opcode      = opcode_t'(cmd_ch.opcode);
        seen.x_pos       = cmd_ch.x_pos;
        seen.y_pos       = cmd_ch.y_pos;
        seen.rect_width  = cmd_ch.rect_width;
        seen.rect_height = cmd_ch.rect_height;
        seen.byte_index  = cmd_ch.byte_index;
        expected_bytes.push_back(apply_fb_cmd(seen));
        cmds_accepted++;
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch($sformatf("response beat 0x%02h with no command outstanding",
                                    rsp_ch.read_data));
        end else begin
          want = expected_bytes.pop_front();
          if (rsp_ch.read_data !== want)
            report_mismatch($sformatf("read_data got 0x%02h want 0x%02h",
                                      rsp_ch.read_data, want));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus, reset and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int pick;
    int w;
    int h;
    rst = 1'b1;
    clear_shadow();

    // directed: reset contents, full-screen fill, clear, clipping, stale page reads
    queue_cmd(OP_READ,  0,   0,  0,   0,  0);   // buffer is zero out of reset
    queue_cmd(OP_READ,  0,   0,  0,   0,  BUF_BYTES - 1);
    queue_cmd(OP_FILL,  0,   0,  127, 31, 0);   // whole screen
    queue_cmd(OP_PACK,  0,   0,  0,   0,  0);
    queue_cmd(OP_READ,  0,   0,  0,   0,  0);
    queue_cmd(OP_READ,  0,   0,  0,   0,  383);
    queue_cmd(OP_READ,  0,   0,  0,   0,  BUF_BYTES - 1);
    queue_cmd(OP_CLEAR, 127, 31, 127, 31, 511); // clear must zero the page bytes too
    queue_cmd(OP_READ,  0,   0,  0,   0,  0);
    queue_cmd(OP_PACK,  0,   0,  0,   0,  0);
    queue_cmd(OP_READ,  0,   0,  0,   0,  200);
    queue_cmd(OP_FILL,  127, 31, 127, 31, 0);   // bottom-right corner, clipped to one pixel
    queue_cmd(OP_FILL,  0,   0,  0,   0,  0);   // single pixel top-left
    queue_cmd(OP_FILL,  60,  5,  10,  12, 0);   // spans three pages
    queue_cmd(OP_FILL,  120, 28, 127, 31, 0);   // clipped on both edges
    queue_cmd(OP_PACK,  0,   0,  0,   0,  0);
    queue_cmd(OP_READ,  0,   0,  0,   0,  0);
    queue_cmd(OP_READ,  0,   0,  0,   0,  127);
    queue_cmd(OP_READ,  0,   0,  0,   0,  BUF_BYTES - 1);
    queue_cmd(OP_READ,  0,   0,  0,   0,  128 + 65);
    queue_cmd(OP_READ,  0,   0,  0,   0,  256 + 62);
    queue_cmd(OP_FILL,  0,   0,  127, 31, 0);   // no pack: reads still show old pages
    queue_cmd(OP_READ,  0,   0,  0,   0,  70);
    queue_cmd(OP_CLEAR, 0,   0,  0,   0,  0);

    // random: mostly reads, then fills (mostly of modest size) and packs; rare clears
    for (int i = 0; i < RAND_CMDS; i++) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 3) != 0) begin
        w = $urandom_range(0, 15);
        h = $urandom_range(0, 7);
      end else begin
        w = $urandom_range(0, 127);
        h = $urandom_range(0, 31);
      end
      queue_cmd(pick < 35 ? OP_FILL : pick < 38 ? OP_CLEAR : pick < 50 ? OP_PACK : OP_READ,
                $urandom_range(0, 127), $urandom_range(0, 31), w, h,
                $urandom_range(0, 511));
    end
    total_cmds = pending_cmds.size();

    // synchronous reset, released on a falling edge
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (cmds_accepted < total_cmds) @(posedge clk);
    while (expected_bytes.size() != 0) @(posedge clk);
    // catch any stray response beat after the last expected one
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_cnt == 0) begin
      $display("mono_framebuffer_rect_fill_page_pack_core verification clean");
    end else begin
      $display("mono_framebuffer_rect_fill_page_pack_core verification failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run (~830 commands plus stalls)
  initial begin
    #5_000_000;
    $display("mono_framebuffer_rect_fill_page_pack_core verification failed");
    $finish;
  end

endmodule
